FILE: design/nqns_pkg.sv
// nqns_pkg: shared constants, types and the control store of the n-queens search unit
// no dependencies; imported by n_queens_next_solution_unit and its testbench
`timescale 1ns / 1ps

package nqns_pkg;

   // field widths fixed by the interface
   localparam int MAX_N_DEFAULT = 8;
   localparam int CFG_W         = 4;
   localparam int CFG_RESET     = 8;
   localparam int ROW_W         = 3;
   localparam int COL_W         = 3;
   localparam int SOL_W         = 16;
   localparam int CNT_W         = 32;

   // sequencer steps, in program order
   typedef enum logic [4:0] {
      S_WAIT,
      S_DISPATCH,
      S_CHOOSE,
      S_LIFT,
      S_UNMARK,
      S_LOAD,
      S_TRY,
      S_TEST,
      S_SKIP,
      S_PLACE,
      S_DOWN,
      S_BACK,
      S_UP,
      S_EXHAUST,
      S_NONE_OUT,
      S_NONE_END,
      S_SOLVED,
      S_EMIT,
      S_EMIT_NEXT,
      S_EMIT_INC
   } step_type;

   // jump conditions
   typedef enum logic [3:0] {
      C_NEVER,
      C_ALWAYS,
      C_NO_REQ,
      C_EXHAUSTED,
      C_FRESH,
      C_COL_END,
      C_FREE,
      C_LAST_ROW,
      C_ROW_ZERO,
      C_OUT_BUSY
   } cond_type;

   // datapath operations
   typedef enum logic [3:0] {
      A_NONE,
      A_ACCEPT,
      A_SET_LAST_ROW,
      A_UNMARK,
      A_LOAD_COL,
      A_INC_COL,
      A_PLACE,
      A_ROW_INC,
      A_BACKTRACK,
      A_SET_EXHAUSTED,
      A_EMIT_NONE,
      A_SOLVED,
      A_EMIT_ROW
   } act_type;

   // one control word: operation, jump condition, jump target
   typedef struct packed {
      act_type  act;
      cond_type cond;
      step_type target;
   } ucode_type;

   // control store; when the condition holds the step jumps, else it falls through
   function automatic ucode_type ucode_rom(step_type s);
      ucode_type w;
      begin
         case (s)
            S_WAIT:      w = '{act: A_ACCEPT,        cond: C_NO_REQ,    target: S_WAIT};
            S_DISPATCH:  w = '{act: A_NONE,          cond: C_EXHAUSTED, target: S_NONE_OUT};
            S_CHOOSE:    w = '{act: A_NONE,          cond: C_FRESH,     target: S_LOAD};
            S_LIFT:      w = '{act: A_SET_LAST_ROW,  cond: C_NEVER,     target: S_WAIT};
            S_UNMARK:    w = '{act: A_UNMARK,        cond: C_ALWAYS,    target: S_LOAD};
            S_LOAD:      w = '{act: A_LOAD_COL,      cond: C_NEVER,     target: S_WAIT};
            S_TRY:       w = '{act: A_NONE,          cond: C_COL_END,   target: S_BACK};
            S_TEST:      w = '{act: A_NONE,          cond: C_FREE,      target: S_PLACE};
            S_SKIP:      w = '{act: A_INC_COL,       cond: C_ALWAYS,    target: S_TRY};
            S_PLACE:     w = '{act: A_PLACE,         cond: C_LAST_ROW,  target: S_SOLVED};
            S_DOWN:      w = '{act: A_ROW_INC,       cond: C_ALWAYS,    target: S_LOAD};
            S_BACK:      w = '{act: A_NONE,          cond: C_ROW_ZERO,  target: S_EXHAUST};
            S_UP:        w = '{act: A_BACKTRACK,     cond: C_ALWAYS,    target: S_UNMARK};
            S_EXHAUST:   w = '{act: A_SET_EXHAUSTED, cond: C_NEVER,     target: S_WAIT};
            S_NONE_OUT:  w = '{act: A_EMIT_NONE,     cond: C_OUT_BUSY,  target: S_NONE_OUT};
            S_NONE_END:  w = '{act: A_NONE,          cond: C_ALWAYS,    target: S_WAIT};
            S_SOLVED:    w = '{act: A_SOLVED,        cond: C_NEVER,     target: S_WAIT};
            S_EMIT:      w = '{act: A_EMIT_ROW,      cond: C_OUT_BUSY,  target: S_EMIT};
            S_EMIT_NEXT: w = '{act: A_NONE,          cond: C_LAST_ROW,  target: S_WAIT};
            S_EMIT_INC:  w = '{act: A_ROW_INC,       cond: C_ALWAYS,    target: S_EMIT};
            default:     w = '{act: A_NONE,          cond: C_ALWAYS,    target: S_WAIT};
         endcase
         return w;
      end
   endfunction

endpackage

FILE: design/n_queens_next_solution_unit.sv
// n_queens_next_solution_unit: microcoded backtracking search for n-queens placements
// depends on nqns_pkg (types, constants, control store)
`timescale 1ns / 1ps

// Each request transaction returns the next placement of N non-attacking queens,
// one result per row (rows 0 to N-1, last on the final row), or a single
// not-found result once the search is exhausted. req_restart = 1 clears the
// search and the counters first; a write of board_size does the same at once.
// How long a request takes depends on the search: the sequencer executes one control
// word per cycle, so each rejected candidate column runs try, test and skip, each
// placement try, test, place, step down and load the next row, each backtrack
// column end, back, up, unmark and reload, plus the dispatch steps and the emit
// steps of each row, which wait while the result side is busy.
// Requests are taken only while the sequencer waits at its first step.
module n_queens_next_solution_unit #(
   parameter int MAX_N = nqns_pkg::MAX_N_DEFAULT
) (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        req_valid,
   output logic                        req_ready,
   input  logic                        req_restart,
   output logic                        rsp_valid,
   input  logic                        rsp_ready,
   output logic                        rsp_found,
   output logic [nqns_pkg::ROW_W-1:0]  rsp_row_index,
   output logic [nqns_pkg::COL_W-1:0]  rsp_queen_column,
   output logic                        rsp_last,
   output logic [nqns_pkg::SOL_W-1:0]  rsp_solution_number,
   output logic [nqns_pkg::CNT_W-1:0]  rsp_move_total,
   output logic [nqns_pkg::CNT_W-1:0]  rsp_backtrack_total,
   input  logic                        csr_write_enable,
   input  logic [nqns_pkg::CFG_W-1:0]  csr_write_data
);

   import nqns_pkg::*;

   localparam int RW = $clog2(MAX_N + 1);
   localparam int IW = (MAX_N > 1) ? $clog2(MAX_N) : 1;
   localparam int DN = 2 * MAX_N - 1;
   localparam int DW = (DN > 1) ? $clog2(DN) : 1;
   localparam int RESET_SIZE = (CFG_RESET > MAX_N) ? MAX_N : CFG_RESET;

   // sequencer and search state
   step_type         upc_ff, upc_in;
   logic [RW-1:0]    size_ff, size_in;
   logic [IW-1:0]    row_ff, row_in;
   logic [RW-1:0]    col_ff, col_in;
   logic [RW-1:0]    ncp1_ff [MAX_N];
   logic [RW-1:0]    ncp1_in [MAX_N];
   logic [MAX_N-1:0] colm_ff, colm_in;
   logic [DN-1:0]    dgu_ff, dgu_in;
   logic [DN-1:0]    dgd_ff, dgd_in;
   logic [SOL_W-1:0] sol_ff, sol_in;
   logic [CNT_W-1:0] moves_ff, moves_in;
   logic [CNT_W-1:0] backs_ff, backs_in;
   logic             exh_ff, exh_in;

   // result register
   logic             rsp_valid_ff, rsp_valid_in;
   logic             found_ff, found_in;
   logic [ROW_W-1:0] ridx_ff, ridx_in;
   logic [COL_W-1:0] qcol_ff, qcol_in;
   logic             last_ff, last_in;
   logic [SOL_W-1:0] osol_ff, osol_in;
   logic [CNT_W-1:0] omove_ff, omove_in;
   logic [CNT_W-1:0] oback_ff, oback_in;

   // datapath signals
   ucode_type              uw;
   logic                   take;
   logic [4:0]             upc_inc;
   logic                   req_fire;
   logic                   out_busy;
   logic                   clear_req;
   logic [RW-1:0]          ncp1_rd;
   logic [RW-1:0]          lift_col;
   logic [IW-1:0]          mcol;
   logic [DW-1:0]          d_up_ix;
   logic [DW-1:0]          d_dn_ix;
   logic                   sq_free;
   logic                   last_row;
   logic [CFG_W:0]         cfg_ext;
   logic [RW-1:0]          cfg_size;
   logic [IW+ROW_W-1:0]    row_wide;
   logic [RW+COL_W-1:0]    qcol_wide;

   // control word fetch and shared datapath terms
   assign uw        = ucode_rom(upc_ff);
   assign req_ready = (upc_ff == S_WAIT);
   assign req_fire  = req_valid & req_ready;
   assign out_busy  = rsp_valid_ff & ~rsp_ready;
   assign clear_req = csr_write_enable | ((uw.act == A_ACCEPT) & req_fire & req_restart);
   assign ncp1_rd   = ncp1_ff[row_ff];
   assign lift_col  = ncp1_rd - RW'(1);
   assign mcol      = (uw.act == A_UNMARK) ? lift_col[IW-1:0] : col_ff[IW-1:0];
   assign d_up_ix   = DW'(row_ff) + DW'(mcol);
   assign d_dn_ix   = DW'(row_ff) + DW'(MAX_N - 1) - DW'(mcol);
   assign sq_free   = ~colm_ff[mcol] & ~dgu_ff[d_up_ix] & ~dgd_ff[d_dn_ix];
   assign last_row  = (RW'(row_ff) == size_ff - RW'(1));
   assign row_wide  = {{ROW_W{1'b0}}, row_ff};
   assign qcol_wide = {{COL_W{1'b0}}, lift_col};

   // board size clamp on a register write
   always_comb begin
      cfg_ext = {1'b0, csr_write_data};
      if (cfg_ext == '0) begin
         cfg_size = RW'(1);
      end else if (cfg_ext > (CFG_W + 1)'(MAX_N)) begin
         cfg_size = RW'(MAX_N);
      end else begin
         cfg_size = RW'(cfg_ext);
      end
   end

   // jump condition select
   always_comb begin
      case (uw.cond)
         C_NEVER:     take = 1'b0;
         C_ALWAYS:    take = 1'b1;
         C_NO_REQ:    take = ~req_fire;
         C_EXHAUSTED: take = exh_ff;
         C_FRESH:     take = (ncp1_rd == '0);
         C_COL_END:   take = (col_ff >= size_ff);
         C_FREE:      take = sq_free;
         C_LAST_ROW:  take = last_row;
         C_ROW_ZERO:  take = (row_ff == '0);
         C_OUT_BUSY:  take = out_busy;
         default:     take = 1'b0;
      endcase
   end

   // next step
   always_comb begin
      upc_inc = upc_ff + 1'b1;
      if (csr_write_enable) begin
         upc_in = S_WAIT;
      end else if (take) begin
         upc_in = uw.target;
      end else begin
         upc_in = step_type'(upc_inc);
      end
   end

   // datapath operations
   always_comb begin
      size_in      = size_ff;
      row_in       = row_ff;
      col_in       = col_ff;
      ncp1_in      = ncp1_ff;
      colm_in      = colm_ff;
      dgu_in       = dgu_ff;
      dgd_in       = dgd_ff;
      sol_in       = sol_ff;
      moves_in     = moves_ff;
      backs_in     = backs_ff;
      exh_in       = exh_ff;
      rsp_valid_in = rsp_valid_ff & ~rsp_ready;
      found_in     = found_ff;
      ridx_in      = ridx_ff;
      qcol_in      = qcol_ff;
      last_in      = last_ff;
      osol_in      = osol_ff;
      omove_in     = omove_ff;
      oback_in     = oback_ff;

      case (uw.act)
         A_ACCEPT: begin
            if (req_fire) begin
               row_in = '0;
            end
         end
         A_SET_LAST_ROW: begin
            row_in = IW'(size_ff - RW'(1));
         end
         A_UNMARK: begin
            colm_in[mcol]  = 1'b0;
            dgu_in[d_up_ix] = 1'b0;
            dgd_in[d_dn_ix] = 1'b0;
         end
         A_LOAD_COL: begin
            col_in = ncp1_rd;
         end
         A_INC_COL: begin
            col_in = col_ff + RW'(1);
         end
         A_PLACE: begin
            ncp1_in[row_ff] = col_ff + RW'(1);
            colm_in[mcol]   = 1'b1;
            dgu_in[d_up_ix] = 1'b1;
            dgd_in[d_dn_ix] = 1'b1;
            moves_in        = (moves_ff == '1) ? moves_ff : moves_ff + 1'b1;
         end
         A_ROW_INC: begin
            row_in = row_ff + IW'(1);
         end
         A_BACKTRACK: begin
            ncp1_in[row_ff] = '0;
            row_in          = row_ff - IW'(1);
            moves_in        = (moves_ff == '1) ? moves_ff : moves_ff + 1'b1;
            backs_in        = (backs_ff == '1) ? backs_ff : backs_ff + 1'b1;
         end
         A_SET_EXHAUSTED: begin
            exh_in = 1'b1;
         end
         A_SOLVED: begin
            sol_in = (sol_ff == '1) ? sol_ff : sol_ff + 1'b1;
            row_in = '0;
         end
         A_EMIT_NONE: begin
            if (!out_busy) begin
               rsp_valid_in = 1'b1;
               found_in     = 1'b0;
               ridx_in      = '0;
               qcol_in      = '0;
               last_in      = 1'b1;
               osol_in      = sol_ff;
               omove_in     = moves_ff;
               oback_in     = backs_ff;
            end
         end
         A_EMIT_ROW: begin
            if (!out_busy) begin
               rsp_valid_in = 1'b1;
               found_in     = 1'b1;
               ridx_in      = row_wide[ROW_W-1:0];
               qcol_in      = qcol_wide[COL_W-1:0];
               last_in      = last_row;
               osol_in      = sol_ff;
               omove_in     = moves_ff;
               oback_in     = backs_ff;
            end
         end
         default: begin
         end
      endcase

      // restart or board size write clears the search
      if (clear_req) begin
         for (int i = 0; i < MAX_N; i++) begin
            ncp1_in[i] = '0;
         end
         colm_in  = '0;
         dgu_in   = '0;
         dgd_in   = '0;
         sol_in   = '0;
         moves_in = '0;
         backs_in = '0;
         exh_in   = 1'b0;
      end
      if (csr_write_enable) begin
         size_in = cfg_size;
      end
   end

   // control and search state registers
   always_ff @(posedge clock) begin
      if (reset) begin
         upc_ff       <= S_WAIT;
         size_ff      <= RW'(RESET_SIZE);
         row_ff       <= '0;
         for (int i = 0; i < MAX_N; i++) begin
            ncp1_ff[i] <= '0;
         end
         colm_ff      <= '0;
         dgu_ff       <= '0;
         dgd_ff       <= '0;
         sol_ff       <= '0;
         moves_ff     <= '0;
         backs_ff     <= '0;
         exh_ff       <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         upc_ff       <= upc_in;
         size_ff      <= size_in;
         row_ff       <= row_in;
         ncp1_ff      <= ncp1_in;
         colm_ff      <= colm_in;
         dgu_ff       <= dgu_in;
         dgd_ff       <= dgd_in;
         sol_ff       <= sol_in;
         moves_ff     <= moves_in;
         backs_ff     <= backs_in;
         exh_ff       <= exh_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // candidate column and result payload
   always_ff @(posedge clock) begin
      col_ff   <= col_in;
      found_ff <= found_in;
      ridx_ff  <= ridx_in;
      qcol_ff  <= qcol_in;
      last_ff  <= last_in;
      osol_ff  <= osol_in;
      omove_ff <= omove_in;
      oback_ff <= oback_in;
   end

   // result port
   assign rsp_valid           = rsp_valid_ff;
   assign rsp_found           = found_ff;
   assign rsp_row_index       = ridx_ff;
   assign rsp_queen_column    = qcol_ff;
   assign rsp_last            = last_ff;
   assign rsp_solution_number = osol_ff;
   assign rsp_move_total      = omove_ff;
   assign rsp_backtrack_total = oback_ff;

`ifndef ASSERT_OFF
   // every backtrack also counts as a move
   a_backs_le_moves: assert property (@(posedge clock) disable iff (reset)
      backs_ff <= moves_ff)
      else $error("backtrack count exceeds move count");

   // the row pointer stays on the board while a request is worked
   a_row_in_range: assert property (@(posedge clock) disable iff (reset)
      (upc_ff != S_WAIT) |-> (RW'(row_ff) < size_ff))
      else $error("row pointer off the board");

   // an exhausted search has lifted every queen
   a_exh_board_empty: assert property (@(posedge clock) disable iff (reset)
      exh_ff |-> (colm_ff == '0 && dgu_ff == '0 && dgd_ff == '0))
      else $error("occupancy left after exhaustion");

   // a not-found transaction always ends its run
   a_none_is_last: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && !found_ff) |-> last_ff)
      else $error("not-found result without last");
`endif

endmodule

FILE: verif/n_queens_next_solution_unit_tb.sv
// n_queens_next_solution_unit_tb: self-checking testbench of the n-queens next-solution unit
// drives request transactions and board_size writes, predicts every result row and compares
// depends on nqns_pkg and n_queens_next_solution_unit
`timescale 1ns / 1ps

module n_queens_next_solution_unit_tb;
   import nqns_pkg::*;

   localparam int  BOARD_MAX      = MAX_N_DEFAULT;
   localparam int  CYCLE_LIMIT    = 4_000_000;
   localparam int  SETTLE_CYCLES  = 16;
   localparam int  RANDOM_PHASES  = 12;
   localparam bit  FIND_NEXT      = 1'b0;
   localparam bit  RESTART_SEARCH = 1'b1;
   localparam int  IDLE_RARE      = 6;
   localparam int  IDLE_OFTEN     = 68;
   localparam int  IDLE_NONE      = 0;

   // one result row as the unit reports it
   typedef struct packed {
      logic             found;
      logic [ROW_W-1:0] row_index;
      logic [COL_W-1:0] queen_column;
      logic             last;
      logic [SOL_W-1:0] solution_number;
      logic [CNT_W-1:0] move_total;
      logic [CNT_W-1:0] backtrack_total;
   } placement_row_type;

   logic             clock;
   logic             reset;
   logic             req_valid;
   logic             req_ready;
   logic             req_restart;
   logic             rsp_valid;
   logic             rsp_ready = 1'b0;
   logic             rsp_found;
   logic [ROW_W-1:0] rsp_row_index;
   logic [COL_W-1:0] rsp_queen_column;
   logic             rsp_last;
   logic [SOL_W-1:0] rsp_solution_number;
   logic [CNT_W-1:0] rsp_move_total;
   logic [CNT_W-1:0] rsp_backtrack_total;
   logic             csr_write_enable;
   logic [CFG_W-1:0] csr_write_data;

   // search state mirrored from the unit
   logic [CFG_W-1:0] board_size_reg;
   logic [3:0]       col_next_p1 [BOARD_MAX];
   bit               queen_on [BOARD_MAX];
   logic [SOL_W-1:0] solution_count;
   logic [CNT_W-1:0] move_count;
   logic [CNT_W-1:0] backtrack_count;
   bit               search_done;

   placement_row_type pending_rows [$];
   int               error_count = 0;
   int               cycle_count = 0;
   int               req_idle_pct = IDLE_RARE;
   int               rsp_idle_pct = IDLE_OFTEN;

   n_queens_next_solution_unit dut (
      .clock               (clock),
      .reset               (reset),
      .req_valid           (req_valid),
      .req_ready           (req_ready),
      .req_restart         (req_restart),
      .rsp_valid           (rsp_valid),
      .rsp_ready           (rsp_ready),
      .rsp_found           (rsp_found),
      .rsp_row_index       (rsp_row_index),
      .rsp_queen_column    (rsp_queen_column),
      .rsp_last            (rsp_last),
      .rsp_solution_number (rsp_solution_number),
      .rsp_move_total      (rsp_move_total),
      .rsp_backtrack_total (rsp_backtrack_total),
      .csr_write_enable    (csr_write_enable),
      .csr_write_data      (csr_write_data)
   );

   // 10 ns clock
   always begin
      clock = 1'b0;
      #5;
      clock = 1'b1;
      #5;
   end

   // run limit
   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("FAILURE");
         $finish;
      end
   end

   // result side back-pressure
   always @(posedge clock) begin
      rsp_ready <= ($urandom_range(99) >= rsp_idle_pct);
   end

   // ---------------------------------------------------------------- predictor

   function automatic logic [CNT_W-1:0] sat_inc(logic [CNT_W-1:0] v);
      return (v == '1) ? v : v + 1'b1;
   endfunction

   function automatic int active_size();
      int n;
      n = int'(board_size_reg);
      if (n < 1) n = 1;
      if (n > BOARD_MAX) n = BOARD_MAX;
      return n;
   endfunction

   function automatic void clear_search_state();
      for (int r = 0; r < BOARD_MAX; r++) begin
         col_next_p1[r] = '0;
         queen_on[r]    = 1'b0;
      end
      solution_count  = '0;
      move_count      = '0;
      backtrack_count = '0;
      search_done     = 1'b0;
   endfunction

   // column and both diagonals against every placed queen
   function automatic bit square_is_safe(int n, int row, int col);
      int q, dc, dr;
      bit safe;
      safe = 1'b1;
      for (int r = 0; r < n; r++) begin
         if (r != row && queen_on[r] && col_next_p1[r] != 0) begin
            q  = int'(col_next_p1[r]) - 1;
            dc = (q > col) ? q - col : col - q;
            dr = (r > row) ? r - row : row - r;
            if (dc == 0 || dc == dr) safe = 1'b0;
         end
      end
      return safe;
   endfunction

   // backtracking from the given row; 1 when a full placement is reached
   function automatic bit run_search(int n, int start_row);
      int row, hit;
      bit finished, solved;
      row      = start_row;
      finished = 1'b0;
      solved   = 1'b0;
      while (!finished) begin
         hit = -1;
         for (int c = int'(col_next_p1[row]); c < n && hit < 0; c++) begin
            if (square_is_safe(n, row, c)) hit = c;
         end
         if (hit >= 0) begin
            col_next_p1[row] = 4'(hit + 1);
            queen_on[row]    = 1'b1;
            move_count       = sat_inc(move_count);
            if (row >= n - 1) begin
               finished = 1'b1;
               solved   = 1'b1;
            end else begin
               row++;
            end
         end else if (row == 0) begin
            finished = 1'b1;
         end else begin
            move_count       = sat_inc(move_count);
            backtrack_count  = sat_inc(backtrack_count);
            queen_on[row-1]  = 1'b0;
            col_next_p1[row] = '0;
            row--;
         end
      end
      return solved;
   endfunction

   // expected rows of one accepted request
   function automatic void predict_request(bit restart);
      int n;
      bit ok;
      placement_row_type item;
      n  = active_size();
      ok = 1'b0;
      if (restart) clear_search_state();
      if (!search_done) begin
         if (col_next_p1[0] == 0 && !queen_on[0]) begin
            ok = run_search(n, 0);
         end else begin
            queen_on[n-1] = 1'b0;
            ok = run_search(n, n - 1);
         end
         if (ok) begin
            if (solution_count != '1) solution_count++;
         end else begin
            search_done = 1'b1;
         end
      end
      item.solution_number = solution_count;
      item.move_total      = move_count;
      item.backtrack_total = backtrack_count;
      if (!ok) begin
         item.found        = 1'b0;
         item.row_index    = '0;
         item.queen_column = '0;
         item.last         = 1'b1;
         pending_rows.push_back(item);
      end else begin
         for (int r = 0; r < n; r++) begin
            item.found        = 1'b1;
            item.row_index    = ROW_W'(r);
            item.queen_column = COL_W'(col_next_p1[r] - 1'b1);
            item.last         = (r == n - 1);
            pending_rows.push_back(item);
         end
      end
   endfunction

   // ---------------------------------------------------------------- checking

   task automatic check_field(input string label, input logic [CNT_W-1:0] want,
                              input logic [CNT_W-1:0] got);
      if (want !== got) begin
         $display("%0t: %s mismatch, expected %0h, actual %0h", $time, label, want, got);
         error_count++;
      end
   endtask

   // compare each result transaction with the oldest expected row
   always @(posedge clock) begin : result_check
      placement_row_type want;
      if (!reset && rsp_valid && rsp_ready) begin
         if (pending_rows.size() == 0) begin
            $display("%0t: unexpected result, expected none, actual found %0b row %0d col %0d",
                     $time, rsp_found, rsp_row_index, rsp_queen_column);
            error_count++;
         end else begin
            want = pending_rows.pop_front();
            check_field("found", CNT_W'(want.found), CNT_W'(rsp_found));
            check_field("row_index", CNT_W'(want.row_index), CNT_W'(rsp_row_index));
            check_field("queen_column", CNT_W'(want.queen_column),
                        CNT_W'(rsp_queen_column));
            check_field("last", CNT_W'(want.last), CNT_W'(rsp_last));
            check_field("solution_number", CNT_W'(want.solution_number),
                        CNT_W'(rsp_solution_number));
            check_field("move_total", want.move_total, rsp_move_total);
            check_field("backtrack_total", want.backtrack_total, rsp_backtrack_total);
         end
      end
   end

   // ---------------------------------------------------------------- stimulus

   // one request transaction, with random idle cycles ahead of it
   task automatic send_request(input bit restart);
      while ($urandom_range(99) < req_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid   <= 1'b1;
      req_restart <= restart;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      predict_request(restart);
   endtask

   // stop sending and let every expected row come back
   task automatic wait_for_idle();
      req_valid <= 1'b0;
      while (pending_rows.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   // board_size write while the unit is idle; it restarts the search
   task automatic write_board_size(input logic [CFG_W-1:0] value);
      wait_for_idle();
      csr_write_enable <= 1'b1;
      csr_write_data   <= value;
      @(posedge clock);
      csr_write_enable <= 1'b0;
      board_size_reg = value;
      clear_search_state();
   endtask

   task automatic set_traffic(input int sender_pct, input int receiver_pct);
      req_idle_pct = sender_pct;
      rsp_idle_pct = receiver_pct;
   endtask

   // eight by eight board from reset, then a restart after two solutions
   task automatic test_default_board();
      send_request(FIND_NEXT);
      send_request(FIND_NEXT);
      send_request(RESTART_SEARCH);
   endtask

   // size zero acts as one: single solution, then repeated not-found, then restart
   task automatic test_single_square();
      write_board_size(4'd0);
      send_request(FIND_NEXT);
      send_request(FIND_NEXT);
      send_request(FIND_NEXT);
      send_request(RESTART_SEARCH);
      write_board_size(4'd1);
      send_request(RESTART_SEARCH);
      send_request(FIND_NEXT);
   endtask

   // boards with no placement at all
   task automatic test_unsolvable_boards();
      write_board_size(4'd2);
      send_request(FIND_NEXT);
      send_request(RESTART_SEARCH);
      write_board_size(4'd3);
      send_request(FIND_NEXT);
   endtask

   // all four six by six solutions one at a time, then exhaustion and restart
   task automatic test_exhaust_six();
      write_board_size(4'd6);
      repeat (5) begin
         send_request(FIND_NEXT);
         wait_for_idle();
      end
      send_request(RESTART_SEARCH);
   endtask

   // size above the maximum is clamped
   task automatic test_oversize_board();
      write_board_size(4'd15);
      send_request(FIND_NEXT);
      send_request(FIND_NEXT);
   endtask

   // phases of random board size and mostly find-next requests
   task automatic test_random_search();
      int items;
      for (int p = 0; p < RANDOM_PHASES; p++) begin
         if (p == RANDOM_PHASES / 3)
            set_traffic(IDLE_OFTEN, IDLE_RARE);
         else if (p == 2 * RANDOM_PHASES / 3)
            set_traffic(IDLE_NONE, IDLE_NONE);
         write_board_size(CFG_W'($urandom_range(15, 0)));
         items = $urandom_range(26, 14);
         for (int i = 0; i < items; i++) begin
            send_request(($urandom_range(99) < 8) ? RESTART_SEARCH : FIND_NEXT);
            if ($urandom_range(29) == 0) wait_for_idle();
         end
      end
   endtask

   initial begin
      reset            <= 1'b1;
      req_valid        <= 1'b0;
      req_restart      <= FIND_NEXT;
      csr_write_enable <= 1'b0;
      csr_write_data   <= '0;
      board_size_reg = CFG_W'(CFG_RESET);
      clear_search_state();
      repeat (2) @(posedge clock);
      reset <= 1'b0;

      set_traffic(IDLE_RARE, IDLE_OFTEN);
      test_default_board();
      test_single_square();
      test_unsolvable_boards();
      test_exhaust_six();
      test_oversize_board();
      test_random_search();

      // drain and let the unit settle
      req_valid <= 1'b0;
      while (pending_rows.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES * 2) @(posedge clock);
      if (error_count == 0) begin
         $display("SUCCESS");
      end else begin
         $display("FAILURE");
      end
      $finish;
   end

endmodule

FILE: files.f
design/nqns_pkg.sv
design/n_queens_next_solution_unit.sv
verif/n_queens_next_solution_unit_tb.sv
